// File: design/wcnc_pkg.sv
// ----------------------------------------------------------------------------
// wcnc_pkg
// Shared constants, register codes and window helpers for the weak cell
// neighbour counter.
// ----------------------------------------------------------------------------
package wcnc_pkg;

    localparam int MAX_ROW_WIDTH = 256;
    localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
    // compare width for column positions against the configured row width
    localparam int CMP_W         = (COL_W + 1 > 9) ? COL_W + 1 : 9;
    localparam int ADDR_W        = 4;

    localparam logic [1:0] REG_ROW_WIDTH      = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT      = 2'd1;
    localparam logic [1:0] REG_WEAK_THRESHOLD = 2'd2;

    localparam logic [8:0]  ROW_WIDTH_RST = 9'd256;
    localparam logic [15:0] ROW_COUNT_RST = 16'd256;
    localparam logic [3:0]  THRESHOLD_RST = 4'd4;

    // three columns of three rows, oldest column in bits 0..2, top row lowest
    typedef logic [8:0] window_t;

    // centre occupied and fewer than thr occupied neighbours
    function automatic logic is_weak(window_t win, logic [3:0] thr);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 0; k < 9; k++)
        begin
            if (k != 4)
            begin
                cnt = cnt + {3'b000, win[k]};
            end
        end
        return win[4] && (cnt < thr);
    endfunction

    // move each column up one row, leaving the bottom row empty
    function automatic window_t lift(window_t win);
        return (win >> 1) & 9'h0DB;
    endfunction

endpackage

// File: design/weak_cell_neighbour_counter.sv
// ----------------------------------------------------------------------------
// weak_cell_neighbour_counter
// Streams a binary grid in row-major order, judges every occupied cell on
// its 3x3 neighbourhood and reports the number of weak cells once per grid.
// ----------------------------------------------------------------------------
//  channel | signals                                  | beat
//  --------+------------------------------------------+-----------------------
//  in      | in_valid, in_stall, occupied             | one cell
//  out     | out_valid, out_stall, weak_total         | one total per grid
//  cfg     | psel, penable, pwrite, paddr, pwdata,    | one register access
//          | prdata, pready                           |
//
//  One cell is taken every cycle while the input is not stalled; the line
//  store read for the next column is fetched at the edge that takes the
//  current cell, so the store port sets the one-cycle rate. The total is
//  registered at the edge that takes the final cell. Reset clears position,
//  accumulator and the line store valid bits at once, with no clearing pass.
//  Input stalls only when a grid's final cell meets a total held by out_stall.
module weak_cell_neighbour_counter
    import wcnc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              occupied,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [23:0]       weak_total,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [8:0]  row_width_reg;
    logic [15:0] row_count_reg;
    logic [3:0]  threshold_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [15:0]      row_reg;
    logic [15:0]      row_next;
    window_t          win_reg;
    logic [23:0]      acc_reg;
    logic             out_valid_reg;
    logic [23:0]      total_reg;

    // line store: bit 1 the row two above, bit 0 the row above
    logic [1:0]               line_mem [MAX_ROW_WIDTH];
    logic [MAX_ROW_WIDTH-1:0] line_vld_reg;
    logic [1:0]               rd_data_reg;
    logic                     rd_vld_reg;
    logic                     byp_reg;
    logic [1:0]               byp_data_reg;

    logic [CMP_W-1:0] width_eff;
    logic             last_col;
    logic             last_row;
    logic             in_acc;
    logic             cfg_wr;
    logic [1:0]       line_rd;
    logic [1:0]       wr_data;
    logic             o_bit;
    logic             p_bit;
    window_t          win_base;
    window_t          win_new;
    window_t          win_lift;
    logic             j0, j1, j2, j3;
    logic [2:0]       judged;
    logic [23:0]      acc_sum;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RST;
            row_count_reg <= ROW_COUNT_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ROW_WIDTH:      row_width_reg <= pwdata[8:0];
                REG_ROW_COUNT:      row_count_reg <= pwdata[15:0];
                REG_WEAK_THRESHOLD: threshold_reg <= pwdata[3:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROW_WIDTH:      prdata = {23'd0, row_width_reg};
            REG_ROW_COUNT:      prdata = {16'd0, row_count_reg};
            REG_WEAK_THRESHOLD: prdata = {28'd0, threshold_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------- grid position ----------------
    always_comb
    begin
        priority if (row_width_reg == 9'd0)
            width_eff = CMP_W'(1);
        else if (CMP_W'(row_width_reg) > CMP_W'(MAX_ROW_WIDTH))
            width_eff = CMP_W'(MAX_ROW_WIDTH);
        else
            width_eff = CMP_W'(row_width_reg);
    end

    assign last_col = (CMP_W'(col_reg) + CMP_W'(1)) >= width_eff;
    // a zero row count stands for 65536 rows
    assign last_row = ({1'b0, row_reg} + 17'd1) >= {row_count_reg == 16'd0, row_count_reg};

    assign in_stall = out_valid_reg && out_stall && last_col && last_row;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? 16'd0 : row_reg + 16'd1;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // ---------------- line store ----------------
    // entries never written since reset read as empty
    assign line_rd = byp_reg ? byp_data_reg : (rd_vld_reg ? rd_data_reg : 2'b00);
    assign wr_data = {line_rd[0], occupied};

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            line_mem[col_reg] <= wr_data;
        end
        rd_data_reg  <= line_mem[col_next];
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                line_vld_reg[col_reg] <= 1'b1;
            end
            rd_vld_reg <= line_vld_reg[col_next];
            // single-column rows read back the entry written at the same edge
            byp_reg    <= in_acc && (col_next == col_reg);
        end
    end

    // ---------------- window and judging ----------------
    assign o_bit    = (row_reg >= 16'd2) && line_rd[1];
    assign p_bit    = (row_reg != 16'd0) && line_rd[0];
    assign win_base = (col_reg == '0) ? 9'd0 : win_reg;
    assign win_new  = (win_base >> 3) | {occupied, p_bit, o_bit, 6'd0};
    assign win_lift = lift(win_new);

    assign j0 = (row_reg != 16'd0) && (col_reg != '0) && is_weak(win_new, threshold_reg);
    assign j1 = (row_reg != 16'd0) && last_col && is_weak(win_new >> 3, threshold_reg);
    // last row: judge it at once against an empty row below
    assign j2 = last_row && (col_reg != '0) && is_weak(win_lift, threshold_reg);
    assign j3 = last_row && last_col && is_weak(win_lift >> 3, threshold_reg);

    assign judged  = {2'b00, j0} + {2'b00, j1} + {2'b00, j2} + {2'b00, j3};
    assign acc_sum = acc_reg + {21'd0, judged};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= 16'd0;
            win_reg <= 9'd0;
            acc_reg <= 24'd0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            win_reg <= win_new;
            acc_reg <= (last_col && last_row) ? 24'd0 : acc_sum;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc && last_col && last_row)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && last_col && last_row)
        begin
            total_reg <= acc_sum;
        end
    end

    assign out_valid  = out_valid_reg;
    assign weak_total = total_reg;

    // ---------------- checks ----------------
    a_result_from_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_acc && last_col && last_row))
        else $error("total raised without a final cell");

    a_grid_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && last_col && last_row) |=>
            (col_reg == '0) && (row_reg == 16'd0) && (acc_reg == 24'd0))
        else $error("position or accumulator not cleared after final cell");

    a_bypass_only_single_column: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> (col_reg == '0))
        else $error("line store bypass outside column zero");

    a_total_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (total_reg == $past(total_reg)))
        else $error("held total overwritten");

endmodule

// File: dv/weak_cell_neighbour_counter_tb.sv
// ----------------------------------------------------------------------------
// weak_cell_neighbour_counter_tb
// Streams binary grids into the weak cell counter and checks each grid total
// against a cycle-free predictor. It also checks every register readback.
// Runs directed grids at the edges of the register ranges, reconfigures
// mid-grid and holds the output for a long stretch. It then sends random
// small grids under four idling regimes.
// ----------------------------------------------------------------------------
module weak_cell_neighbour_counter_tb;
    import wcnc_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 300;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              occupied = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [23:0]       weak_total;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    // predictor state: two line stores, 3x3 window, raster position, running sum
    bit                upper_row [MAX_ROW_WIDTH];
    bit                above_row [MAX_ROW_WIDTH];
    bit [8:0]          nbhd;
    int unsigned       col_pos;
    int unsigned       row_pos;
    bit [23:0]         weak_sum;
    bit [8:0]          cfg_width = ROW_WIDTH_RST;
    bit [15:0]         cfg_rows  = ROW_COUNT_RST;
    bit [3:0]          cfg_thr   = THRESHOLD_RST;

    bit                cell_q [$];
    bit [23:0]         total_q [$];

    int                errors        = 0;
    int                cells_taken   = 0;
    int                totals_seen   = 0;
    int                settings_used = 0;
    int                send_idle_pct = 0;
    int                stall_pct     = 0;
    int                hold_asked    = 0;
    int                hold_done     = 0;
    int                hold_left     = 0;

    weak_cell_neighbour_counter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .occupied   (occupied),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .weak_total (weak_total),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bit centre_weak(bit [8:0] win);
        return win[4] && ($countones(win & 9'h1EF) < int'(cfg_thr));
    endfunction

    // take one cell; queue the grid total when it is the final one
    function automatic void advance_grid(bit occ);
        int unsigned span;
        int unsigned depth;
        int unsigned c;
        int unsigned r;
        int unsigned hits;
        bit          up_bit;
        bit          mid_bit;
        bit          last_c;
        bit          last_r;
        bit [8:0]    lifted;
        span  = (cfg_width == 9'd0) ? 1 : 32'(cfg_width);
        if (span > MAX_ROW_WIDTH)
            span = MAX_ROW_WIDTH;
        depth = (cfg_rows == 16'd0) ? 65536 : 32'(cfg_rows);
        c     = (col_pos >= MAX_ROW_WIDTH) ? MAX_ROW_WIDTH - 1 : col_pos;
        r     = row_pos;
        last_c = (c + 1 >= span);
        last_r = (r + 1 >= depth);
        if (c == 0)
            nbhd = '0;
        // rows above the top of this grid read as empty
        up_bit  = (r >= 2) && upper_row[c];
        mid_bit = (r >= 1) && above_row[c];
        upper_row[c] = above_row[c];
        above_row[c] = occ;
        nbhd = {occ, mid_bit, up_bit, nbhd[8:3]};
        hits = 0;
        if (r >= 1 && c >= 1)
            hits += 32'(centre_weak(nbhd));
        if (r >= 1 && last_c)
            hits += 32'(centre_weak(nbhd >> 3));
        if (last_r)
        begin
            // judge the last row now, with an empty row below it
            lifted = (nbhd >> 1) & 9'h0DB;
            if (c >= 1)
                hits += 32'(centre_weak(lifted));
            if (last_c)
                hits += 32'(centre_weak(lifted >> 3));
        end
        weak_sum = weak_sum + 24'(hits);
        if (last_c)
        begin
            col_pos = 0;
            if (last_r)
            begin
                total_q.insert(total_q.size(), weak_sum);
                row_pos  = 0;
                weak_sum = '0;
                nbhd     = '0;
            end
            else
                row_pos = (r + 1) & 32'hFFFF;
        end
        else
            col_pos = c + 1;
    endfunction

    // driver: advance the payload only when the current beat has gone
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (cell_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                occupied <= cell_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
                occupied <= 1'($urandom_range(1));
            end
        end
    end

    // receiver: a requested long hold wins over random stalling
    always @(posedge clk)
    begin
        if (hold_done != hold_asked)
        begin
            hold_done <= hold_asked;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor: predict on each input beat, check each output beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                advance_grid(occupied);
                cells_taken++;
            end
            if (out_valid && !out_stall)
            begin
                if (total_q.size() == 0)
                begin
                    $display("%0t: weak_total beat with none expected, actual %0d",
                             $time, weak_total);
                    errors++;
                end
                else
                begin
                    if (weak_total !== total_q[0])
                    begin
                        $display("%0t: weak_total mismatch, expected %0d, actual %0d",
                                 $time, total_q[0], weak_total);
                        errors++;
                    end
                    void'(total_q.pop_front());
                    totals_seen++;
                end
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (wr)
        begin
            case (idx)
                REG_ROW_WIDTH:      cfg_width = wdata[8:0];
                REG_ROW_COUNT:      cfg_rows  = wdata[15:0];
                REG_WEAK_THRESHOLD: cfg_thr   = wdata[3:0];
                default:            ;
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        apb_access(1'b0, idx, 32'($urandom), got);
        if (got !== want)
        begin
            $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                     $time, idx, want, got);
            errors++;
        end
        @(negedge clk);
    endtask

    // write with junk above the register width, then read it back
    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        logic [31:0] mask;
        logic [31:0] data;
        logic [31:0] unused;
        case (idx)
            REG_ROW_WIDTH: mask = 32'h1FF;
            REG_ROW_COUNT: mask = 32'hFFFF;
            default:       mask = 32'hF;
        endcase
        data = (32'($urandom) & ~mask) | (value & mask);
        apb_access(1'b1, idx, data, unused);
        check_reg(idx, data & mask);
    endtask

    // wait until the block has taken everything and delivered every total
    task automatic settle();
        do
            @(negedge clk);
        while (cell_q.size() != 0 || in_valid || total_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input int unsigned w, input int unsigned r,
                                 input int unsigned t);
        settle();
        write_reg(REG_ROW_WIDTH, w);
        write_reg(REG_ROW_COUNT, r);
        write_reg(REG_WEAK_THRESHOLD, t);
        settings_used++;
    endtask

    task automatic queue_grid(input int unsigned cells, input int unsigned density);
        repeat (cells)
            cell_q.insert(cell_q.size(), $urandom_range(99) < density);
    endtask

    initial
    begin
        int unsigned w;
        int unsigned r;
        int unsigned t;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        check_reg(REG_ROW_WIDTH, 32'(ROW_WIDTH_RST));
        check_reg(REG_ROW_COUNT, 32'(ROW_COUNT_RST));
        check_reg(REG_WEAK_THRESHOLD, 32'(THRESHOLD_RST));

        // single-cell grids, occupied then empty
        apply_setting(1, 1, 4);
        cell_q.insert(cell_q.size(), 1'b1);
        cell_q.insert(cell_q.size(), 1'b0);
        // full 3x3: only the corners fall short of four neighbours
        apply_setting(3, 3, 4);
        queue_grid(9, 100);
        // zero width acts as one column; threshold above nine makes all weak
        apply_setting(0, 2, 15);
        queue_grid(2, 100);
        // zero row count, then narrow the row and cut the grid short mid-stream
        apply_setting(5, 0, 9);
        queue_grid(7, 60);
        settle();
        write_reg(REG_ROW_WIDTH, 2);
        cell_q.insert(cell_q.size(), 1'b1);
        settle();
        write_reg(REG_ROW_COUNT, 1);
        queue_grid(2, 100);
        // threshold zero: nothing is weak
        apply_setting(2, 2, 0);
        queue_grid(4, 100);

        // long output hold: totals back up until the input stalls
        apply_setting(1, 1, 4);
        hold_asked++;
        queue_grid(12, 50);

        // widest rows: oversize width saturates, top row count; then narrow
        // the row and cut the grid short one cell into the second row
        apply_setting(511, 65535, 3);
        queue_grid(256, 50);
        settle();
        write_reg(REG_ROW_WIDTH, 1);
        write_reg(REG_ROW_COUNT, 2);
        queue_grid(1, 50);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 56 : (ph == 3) ? 37 : 0;
            stall_pct     = (ph == 2) ? 56 : (ph == 3) ? 37 : 0;
            repeat (3)
            begin
                w = $urandom_range(0, 6);
                r = $urandom_range(1, 5);
                t = ($urandom_range(1) != 0) ? $urandom_range(2, 6) : $urandom_range(0, 15);
                apply_setting(w, r, t);
                // back-to-back grids reuse stale line store contents
                repeat ($urandom_range(1, 3))
                    queue_grid(((w == 0) ? 1 : w) * r, $urandom_range(0, 100));
            end
        end

        settle();
        $display("cells streamed %0d, grid totals checked %0d, register settings %0d",
                 cells_taken, totals_seen, settings_used);
        $display("covered range edges, mid-grid changes, a long output hold, four idle mixes");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
